### hdl/assert_macros.svh
// Assertion macros used by the checker module of the TGA decoder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/trle_pkg.sv
// Types and constants of the TGA run-length pixel decoder.
// Used by every RTL module of the block; depends on nothing.
package trle_pkg;

    localparam int CMD_QUEUE_DEPTH = 4;
    localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
    localparam logic [7:0] RUN_HEADER_BIAS = 8'd127;
    localparam logic [15:0] MIN_WIDTH = 16'd4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COMPRESSED_MODE = 3'd0,
        CFG_PIXEL_BITS      = 3'd1,
        CFG_IMAGE_WIDTH     = 3'd2,
        CFG_IMAGE_HEIGHT    = 3'd3,
        CFG_FLIP_ROWS       = 3'd4
    } cfg_index_t;

    localparam logic [1:0] PIX_GRAY = 2'd0;
    localparam logic [1:0] PIX_BGR  = 2'd1;
    localparam logic [1:0] PIX_BGRA = 2'd2;

    typedef struct packed {
        logic        compressed_mode;
        logic [1:0]  pixel_bits;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        flip_rows;
    } cfg_t;

    // One command from the front end: an optional restart and an optional pixel.
    typedef struct packed {
        logic       clear;
        logic       has_pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] count;
    } cmd_t;

endpackage

### hdl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: configuration registers and
// the front end, command queue and span generator. Depends on trle_pkg.
//
//   Channel  Direction  Payload
//   s_*      in         tdata: data_byte; tuser: first_of_image
//   m_*      out        tdata: RGBA, out_row, out_column, span_length;
//                       tlast: last_of_item; tuser: image_done
//   cfg_*    in         write of one register: index, data
//
// The front end takes one byte per cycle while the command queue has room.
// The span generator emits one span per cycle while the receiver takes them,
// so a pixel yields one span per row that its run touches; a run over narrow
// rows fills the queue and then holds s_tready low.
// Reset is asynchronous and needs no clearing pass.
module tga_rle_pixel_decoder
    import trle_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] first_of_image
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [47:32] out_row, [63:48] out_column, [71:64] span_length
    output logic [71:0]            m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser,   // [0] image_done
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg_reg;
    logic cmd_push;
    cmd_t cmd;
    logic queue_full;
    logic cmd_pop;
    logic head_valid;
    cmd_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compressed_mode <= 1'b0;
            cfg_reg.pixel_bits <= PIX_BGRA;
            cfg_reg.image_width <= 16'd4;
            cfg_reg.image_height <= 16'd1;
            cfg_reg.flip_rows <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMPRESSED_MODE: cfg_reg.compressed_mode <= cfg_wdata[0];
                CFG_PIXEL_BITS:      cfg_reg.pixel_bits <= cfg_wdata[1:0];
                CFG_IMAGE_WIDTH:     cfg_reg.image_width <= cfg_wdata;
                CFG_IMAGE_HEIGHT:    cfg_reg.image_height <= cfg_wdata;
                CFG_FLIP_ROWS:       cfg_reg.flip_rows <= cfg_wdata[0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    trle_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .data_byte      (s_tdata),
        .first_of_image (s_tuser),
        .queue_full     (queue_full),
        .cmd_push       (cmd_push),
        .cmd            (cmd)
    );

    trle_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (cmd),
        .full       (queue_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    trle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (cmd_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast),
        .out_done   (m_tuser)
    );

endmodule

### hdl/trle_front.sv
// Front end: parses packet headers and assembles pixels from the byte stream.
// Depends on trle_pkg; feeds commands to trle_cmd_queue.
module trle_front
    import trle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_of_image,
    input  logic       queue_full,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [7:0] packet_left_reg, packet_left_next;
    logic       packet_is_run_reg, packet_is_run_next;
    logic [1:0] byte_in_pixel_reg, byte_in_pixel_next;
    logic [7:0] pixel_bytes_reg [3];

    logic [7:0] pl_cur;
    logic       run_cur;
    logic [1:0] bip_cur;
    logic [1:0] last_idx;
    logic       accept;
    logic       complete;
    logic       pb_wr_en;
    logic [1:0] pb_wr_idx;

    assign in_ready = !queue_full;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        case (cfg.pixel_bits)
            PIX_GRAY: last_idx = 2'd0;
            PIX_BGR:  last_idx = 2'd2;
            default:  last_idx = 2'd3;
        endcase
    end

    always_comb
    begin
        pl_cur = first_of_image ? 8'd0 : packet_left_reg;
        run_cur = first_of_image ? 1'b0 : packet_is_run_reg;
        bip_cur = first_of_image ? 2'd0 : byte_in_pixel_reg;
        packet_left_next = packet_left_reg;
        packet_is_run_next = packet_is_run_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        pb_wr_en = 1'b0;
        pb_wr_idx = (bip_cur == 2'd3) ? 2'd2 : bip_cur;
        complete = 1'b0;
        cmd = '0;
        cmd_push = 1'b0;
        if (accept)
        begin
            packet_left_next = pl_cur;
            packet_is_run_next = run_cur;
            byte_in_pixel_next = bip_cur;
            if (cfg.compressed_mode && pl_cur == 8'd0)
            begin
                if (data_byte < RUN_HEADER_MIN)
                begin
                    packet_left_next = data_byte + 8'd1;
                    packet_is_run_next = 1'b0;
                end
                else
                begin
                    packet_left_next = data_byte - RUN_HEADER_BIAS;
                    packet_is_run_next = 1'b1;
                end
            end
            else if (bip_cur < last_idx)
            begin
                pb_wr_en = 1'b1;
                byte_in_pixel_next = bip_cur + 2'd1;
            end
            else
            begin
                complete = 1'b1;
                byte_in_pixel_next = 2'd0;
                cmd.count = 8'd1;
                if (cfg.compressed_mode)
                begin
                    if (run_cur)
                    begin
                        cmd.count = pl_cur;
                        packet_left_next = 8'd0;
                    end
                    else
                    begin
                        packet_left_next = pl_cur - 8'd1;
                    end
                end
                case (cfg.pixel_bits)
                    PIX_GRAY:
                    begin
                        cmd.red = data_byte;
                    end
                    PIX_BGR:
                    begin
                        cmd.red = data_byte;
                        cmd.green = pixel_bytes_reg[1];
                        cmd.blue = pixel_bytes_reg[0];
                    end
                    default:
                    begin
                        cmd.red = pixel_bytes_reg[2];
                        cmd.green = pixel_bytes_reg[1];
                        cmd.blue = pixel_bytes_reg[0];
                        cmd.alpha = data_byte;
                    end
                endcase
            end
            cmd.clear = first_of_image;
            cmd.has_pixel = complete;
            cmd_push = complete || first_of_image;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_left_reg <= '0;
            packet_is_run_reg <= 1'b0;
            byte_in_pixel_reg <= '0;
        end
        else
        begin
            packet_left_reg <= packet_left_next;
            packet_is_run_reg <= packet_is_run_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pb_wr_en)
        begin
            pixel_bytes_reg[pb_wr_idx] <= data_byte;
        end
    end

endmodule

### hdl/trle_cmd_queue.sv
// Short command queue between the front end and the span generator.
// Depends on trle_pkg for the command type.
module trle_cmd_queue
    import trle_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/trle_back.sv
// Back end: turns pixel commands into row-clipped spans, one per cycle unless stalled.
// Depends on trle_pkg; takes commands from trle_cmd_queue.
module trle_back
    import trle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        head_valid,
    input  cmd_t        head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [71:0] out_data,
    output logic        out_last,
    output logic        out_done
);

    logic        active_reg, active_next;
    logic [7:0]  n_reg, n_next;
    logic [31:0] pixel_reg, pixel_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic        all_done_reg, all_done_next;
    logic        out_valid_reg, out_valid_next;
    logic [71:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    logic        out_done_reg, out_done_next;

    logic [15:0] w;
    logic [15:0] h;
    logic        cur_clear;
    logic [7:0]  cur_n;
    logic [31:0] cur_pixel;
    logic [15:0] col0;
    logic [16:0] row0;
    logic        done0;
    logic        wrap0;
    logic [15:0] col1;
    logic [16:0] row1;
    logic        ends_pre;
    logic [15:0] room;
    logic [7:0]  len;
    logic [16:0] col2;
    logic        col_full;
    logic [16:0] row2;
    logic        done_span;
    logic [7:0]  n_left;
    logic        finish;
    logic        step;
    logic [15:0] dest_row;

    assign w = (cfg.image_width < MIN_WIDTH) ? MIN_WIDTH : cfg.image_width;
    assign h = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;

    assign cur_clear = !active_reg && head.clear;
    assign cur_n = active_reg ? n_reg : (head.has_pixel ? head.count : 8'd0);
    assign cur_pixel = active_reg ? pixel_reg : {head.alpha, head.blue, head.green, head.red};

    assign col0 = cur_clear ? 16'd0 : col_reg;
    assign row0 = cur_clear ? 17'd0 : {1'b0, row_reg};
    assign done0 = cur_clear ? 1'b0 : all_done_reg;
    assign wrap0 = (col0 >= w);
    assign col1 = wrap0 ? 16'd0 : col0;
    assign row1 = wrap0 ? row0 + 17'd1 : row0;
    assign ends_pre = (row1 >= {1'b0, h});

    assign room = w - col1;
    assign len = ({8'd0, cur_n} <= room) ? cur_n : room[7:0];
    assign col2 = {1'b0, col1} + {9'd0, len};
    assign col_full = (col2 >= {1'b0, w});
    assign row2 = row1 + 17'd1;
    assign done_span = col_full && (row2 >= {1'b0, h});
    assign n_left = cur_n - len;
    assign dest_row = cfg.flip_rows ? (h - 16'd1 - row1[15:0]) : row1[15:0];

    assign step = (active_reg || head_valid) && (!out_valid_reg || out_ready);

    always_comb
    begin
        active_next = active_reg;
        n_next = n_reg;
        pixel_next = pixel_reg;
        col_next = col_reg;
        row_next = row_reg;
        all_done_next = all_done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_done_next = out_done_reg;
        finish = 1'b1;
        pop = 1'b0;
        if (step)
        begin
            col_next = col0;
            row_next = row0[15:0];
            all_done_next = done0;
            if (!done0 && cur_n != 8'd0)
            begin
                col_next = col1;
                row_next = row1[15:0];
                if (ends_pre)
                begin
                    all_done_next = 1'b1;
                end
                else
                begin
                    col_next = col_full ? 16'd0 : col2[15:0];
                    row_next = col_full ? row2[15:0] : row1[15:0];
                    all_done_next = done_span;
                    finish = (n_left == 8'd0) || done_span;
                    out_valid_next = 1'b1;
                    out_data_next = {len, col1, dest_row, cur_pixel};
                    out_last_next = finish;
                    out_done_next = done_span;
                end
            end
            pop = !active_reg;
            active_next = !finish;
            n_next = n_left;
            pixel_next = cur_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
            all_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            col_reg <= col_next;
            row_reg <= row_next;
            all_done_reg <= all_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        pixel_reg <= pixel_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;
    assign out_done = out_done_reg;

endmodule

### hdl/trle_checker.sv
// Port-level checks of the TGA run-length pixel decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module trle_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // A stalled span keeps its payload.
`ASSERT_CLKRST(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled span changed")
    // Spans are between one and 128 pixels long.
`ASSERT_CLKRST(a_span_len, clk, rst_n, m_tvalid |-> m_tdata[71:64] != 8'd0 && m_tdata[71:64] <= 8'd128, "span length out of range")
    // The span that finishes the image is the last of its pixel.
`ASSERT_CLKRST(a_done_last, clk, rst_n, m_tvalid && m_tuser |-> m_tlast, "image done without last")
    // A run that continues past a row yields its next span at once, same pixel.
`ASSERT_CLKRST(a_run_next, clk, rst_n, m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tdata[31:0] == $past(m_tdata[31:0]), "run span missing or changed")
    // No span is offered while reset is held.
`ASSERT_CLK(a_reset_idle, clk, !rst_n |-> !m_tvalid, "span offered during reset")

endmodule

bind tga_rle_pixel_decoder trle_checker u_checker (.*);

### sim/tga_rle_pixel_decoder_tb.sv
// Self-checking testbench for the TGA run-length pixel decoder.
// Sends byte streams with random pacing, predicts every span with its own
// decoder model and compares each result field by field. Depends on trle_pkg.
module tga_rle_pixel_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trle_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BYTES = 160;
    localparam logic [1:0] PIX_UNDEF = 2'd3;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] row;
        logic [15:0] column;
        logic [7:0]  length;
        logic        tail;
        logic        image_end;
    } span_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [71:0]            m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    span_t pending_spans[$];
    int    error_count = 0;
    int    cycle_count = 0;
    int    bytes_decoded = 0;
    int    hold_cycles = 0;
    int    phase_bytes = 0;
    bit    quiet = 1'b0;
    bit    sof_pending = 1'b0;

    logic        cur_compressed = 1'b0;
    logic [1:0]  cur_pix_bits = PIX_BGRA;
    logic [15:0] cur_width = MIN_WIDTH;
    logic [15:0] cur_height = 16'd1;
    logic        cur_flip = 1'b0;
    int          pkt_remaining = 0;
    bit          pkt_run = 1'b0;
    int          pix_pos = 0;
    logic [7:0]  pix_hold [3];
    int          col_pos = 0;
    int          row_pos = 0;
    bit          image_over = 1'b0;

    tga_rle_pixel_decoder u_top (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(12, 30);
    endfunction

    function automatic int receiver_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(12, 30);
    endfunction

    function automatic int pixel_size();
        if (cur_pix_bits == PIX_GRAY)
            return 1;
        if (cur_pix_bits == PIX_BGR)
            return 3;
        return 4;
    endfunction

    // The receiver alternates bursts of ready with stalls; a requested hold-off wins.
    initial
    begin
        int ready_run;
        int ready_gap;
        ready_run = 0;
        ready_gap = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else if (ready_run > 0)
            begin
                m_tready <= 1'b1;
                ready_run--;
            end
            else if (ready_gap > 0)
            begin
                m_tready <= 1'b0;
                ready_gap--;
            end
            else
            begin
                ready_run = $urandom_range(0, 30);
                ready_gap = receiver_gap();
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_span
        span_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_spans.size() == 0)
                report_mismatch("span arrived with no expected span pending");
            else
            begin
                want = pending_spans.pop_front();
                check_field("red", 16'(m_tdata[7:0]), 16'(want.red));
                check_field("green", 16'(m_tdata[15:8]), 16'(want.green));
                check_field("blue", 16'(m_tdata[23:16]), 16'(want.blue));
                check_field("alpha", 16'(m_tdata[31:24]), 16'(want.alpha));
                check_field("out_row", m_tdata[47:32], want.row);
                check_field("out_column", m_tdata[63:48], want.column);
                check_field("span_length", 16'(m_tdata[71:64]), 16'(want.length));
                check_field("last_of_item", 16'(m_tlast), 16'(want.tail));
                check_field("image_done", 16'(m_tuser), 16'(want.image_end));
            end
        end
    end

    // Decoder model: updated once per accepted request, queues the spans it causes.
    task automatic decode_byte(input logic [7:0] b, input logic sof);
        int         size;
        int         n;
        int         w;
        int         h;
        int         room;
        int         len;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] bl;
        logic [7:0] a;
        span_t      s;
        span_t      spans[$];
        if (sof)
        begin
            pkt_remaining = 0;
            pkt_run = 1'b0;
            pix_pos = 0;
            col_pos = 0;
            row_pos = 0;
            image_over = 1'b0;
        end
        if (image_over)
            return;
        bytes_decoded++;
        if (cur_compressed && pkt_remaining == 0)
        begin
            if (b < RUN_HEADER_MIN)
            begin
                pkt_remaining = int'(b) + 1;
                pkt_run = 1'b0;
            end
            else
            begin
                pkt_remaining = int'(b) - int'(RUN_HEADER_BIAS);
                pkt_run = 1'b1;
            end
            return;
        end
        size = pixel_size();
        if (pix_pos + 1 < size)
        begin
            pix_hold[pix_pos > 2 ? 2 : pix_pos] = b;
            pix_pos++;
            return;
        end
        pix_pos = 0;
        if (size == 1)
        begin
            r = b;
            g = 8'd0;
            bl = 8'd0;
            a = 8'd0;
        end
        else if (size == 3)
        begin
            r = b;
            g = pix_hold[1];
            bl = pix_hold[0];
            a = 8'd0;
        end
        else
        begin
            r = pix_hold[2];
            g = pix_hold[1];
            bl = pix_hold[0];
            a = b;
        end
        n = 1;
        if (cur_compressed)
        begin
            if (pkt_run)
            begin
                n = pkt_remaining;
                pkt_remaining = 0;
            end
            else
                pkt_remaining--;
        end
        w = cur_width < MIN_WIDTH ? int'(MIN_WIDTH) : int'(cur_width);
        h = cur_height == 16'd0 ? 1 : int'(cur_height);
        while (n > 0 && !image_over)
        begin
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h)
            begin
                image_over = 1'b1;
                break;
            end
            room = w - col_pos;
            len = n < room ? n : room;
            s.red = r;
            s.green = g;
            s.blue = bl;
            s.alpha = a;
            s.row = cur_flip ? 16'(h - 1 - row_pos) : 16'(row_pos);
            s.column = 16'(col_pos);
            s.length = 8'(len);
            s.tail = 1'b0;
            s.image_end = 1'b0;
            col_pos += len;
            n -= len;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h)
                begin
                    image_over = 1'b1;
                    s.image_end = 1'b1;
                end
            end
            spans.push_back(s);
        end
        if (spans.size() > 0)
            spans[spans.size() - 1].tail = 1'b1;
        foreach (spans[i])
            pending_spans.push_back(spans[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sof);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= sof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_byte(b, sof);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_spans.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_COMPRESSED_MODE: cur_compressed = val[0];
            CFG_PIXEL_BITS:      cur_pix_bits = val[1:0];
            CFG_IMAGE_WIDTH:     cur_width = val;
            CFG_IMAGE_HEIGHT:    cur_height = val;
            CFG_FLIP_ROWS:       cur_flip = val[0];
            default:             ;
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] comp, input logic [15:0] pix,
                             input logic [15:0] width, input logic [15:0] height,
                             input logic [15:0] flip);
        write_reg(CFG_COMPRESSED_MODE, comp);
        write_reg(CFG_PIXEL_BITS, pix);
        write_reg(CFG_IMAGE_WIDTH, width);
        write_reg(CFG_IMAGE_HEIGHT, height);
        write_reg(CFG_FLIP_ROWS, flip);
        cfg_we <= 1'b0;
    endtask

    task automatic emit(input logic [7:0] b);
        send_byte(b, sof_pending || $urandom_range(0, 99) == 0);
        sof_pending = 1'b0;
        phase_bytes++;
    endtask

    task automatic emit_pixel();
        repeat (pixel_size())
            emit(8'($urandom_range(0, 255)));
    endtask

    // Gray pixels in raw mode on a narrow, zero-height image, then a byte past its end.
    task automatic test_raw_gray();
        wait_idle();
        configure(16'd0, 16'(PIX_GRAY), 16'd2, 16'd0, 16'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h3C, 1'b1);
    endtask

    // A full-length run with the undefined pixel code runs past the image end.
    task automatic test_run_past_end();
        wait_idle();
        configure(16'd1, 16'(PIX_UNDEF), 16'd4, 16'd2, 16'd1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h77, 1'b0);
    endtask

    // Largest image size with 24-bit pixels: longest run and longest raw packet.
    task automatic test_wide_bgr();
        wait_idle();
        configure(16'd1, 16'(PIX_BGR), 16'hFFFF, 16'hFFFF, 16'd1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h50, 1'b0);
        send_byte(8'h60, 1'b0);
    endtask

    // Shrinking the size in mid-image wraps the column, then ends the image.
    task automatic test_resize_mid_image();
        wait_idle();
        configure(16'd0, 16'(PIX_GRAY), 16'd5, 16'd2, 16'd0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h42, 1'b0);
        send_byte(8'h24, 1'b0);
        send_byte(8'h18, 1'b0);
        wait_idle();
        configure(16'd0, 16'(PIX_GRAY), 16'd4, 16'd2, 16'd0);
        send_byte(8'hC3, 1'b0);
        wait_idle();
        configure(16'd0, 16'(PIX_GRAY), 16'd4, 16'd1, 16'd0);
        send_byte(8'h99, 1'b0);
    endtask

    // Long runs over narrow rows while the receiver holds off fill the decoder.
    task automatic test_backpressure();
        wait_idle();
        configure(16'd1, 16'(PIX_GRAY), 16'd4, 16'd200, 16'd0);
        hold_cycles = 300;
        for (int i = 0; i < 6; i++)
        begin
            send_byte(8'hFF, i == 0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_random();
        int          goal;
        int          budget;
        int          r;
        int          k;
        logic [15:0] width;
        logic [15:0] height;
        goal = bytes_decoded + RANDOM_BYTES;
        while (bytes_decoded < goal)
        begin
            wait_idle();
            quiet = $urandom_range(0, 4) == 0;
            r = $urandom_range(0, 99);
            width = r < 65 ? 16'($urandom_range(4, 10)) :
                    r < 80 ? 16'($urandom_range(0, 3)) :
                    r < 93 ? 16'($urandom_range(11, 300)) :
                    r < 97 ? 16'hFFFF : 16'($urandom);
            r = $urandom_range(0, 99);
            height = r < 65 ? 16'($urandom_range(1, 4)) :
                     r < 75 ? 16'd0 :
                     r < 93 ? 16'($urandom_range(5, 30)) :
                     r < 97 ? 16'hFFFF : 16'($urandom);
            configure($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)),
                      width, height,
                      $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1)));
            sof_pending = 1'b1;
            phase_bytes = 0;
            budget = $urandom_range(12, 60);
            while (phase_bytes < budget)
            begin
                if (image_over && !sof_pending)
                begin
                    emit(8'($urandom_range(0, 255)));
                    emit(8'($urandom_range(0, 255)));
                    break;
                end
                if (!cur_compressed)
                    emit_pixel();
                else if ($urandom_range(0, 99) < 5)
                    emit(8'($urandom_range(0, 255)));
                else
                begin
                    k = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127) :
                                                    $urandom_range(0, 7);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        emit(RUN_HEADER_MIN + 8'(k));
                        emit_pixel();
                    end
                    else
                    begin
                        emit(8'(k));
                        for (int p = 0; p <= k && phase_bytes < budget; p++)
                            emit_pixel();
                    end
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_COMPRESSED_MODE;
        cfg_wdata = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_raw_gray();
        test_run_past_end();
        test_wide_bgr();
        test_resize_mid_image();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
